// ===== rtl/fence_ack_range_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// fence ack range tracker assertion macros
// concurrent checks that disappear when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef FENCE_ACK_RANGE_TRACKER_DEFINES_SVH
`define FENCE_ACK_RANGE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// check masked while reset is high
`define FATR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define FATR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FATR_ASSERT(lbl, clk, rst, prop, msg)
`define FATR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/fatr_pkg.sv =====
// ----------------------------------------------------------------------------
// fatr_pkg
// shared types, operation codes and sequence helpers of the range tracker
// ----------------------------------------------------------------------------
`default_nettype none

package fatr_pkg;

   // operation codes
   localparam logic [1:0] FUNC_ACK   = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] ack_seq;
   } req_type;

   typedef struct packed {
      logic [31:0] popped_lower;
      logic [31:0] latched_upper;
      logic        ranges_pending;
      logic        duplicate_ack;
      logic        table_overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY
   } state_type;

   // what a cell shows its neighbours
   typedef struct packed {
      logic        valid;
      logic        merge;
      logic [31:0] low;
      logic [31:0] high;
   } nbr_type;

   // flags rippling down the chain during the update
   typedef struct packed {
      logic found;
      logic shift_r;
      logic shift_l;
      logic dup;
      logic ovf;
   } chain_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic        eval_en;
      logic        apply_en;
      logic        full;
      logic [1:0]  func;
      logic [31:0] seq;
   } ctl_type;

   // next sequence, skipping zero
   function automatic logic [31:0] seq_succ(input logic [31:0] s);
      logic [31:0] r;
      r = s + 32'd1;
      if (r == 32'd0) begin
         r = 32'd1;
      end
      return r;
   endfunction

   // previous sequence, skipping zero
   function automatic logic [31:0] seq_pred(input logic [31:0] s);
      logic [31:0] r;
      r = s - 32'd1;
      if (r == 32'd0) begin
         r = 32'hFFFF_FFFF;
      end
      return r;
   endfunction

   // serial order: a before b when the wrapped difference is negative
   function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fatr_cell.sv =====
// ----------------------------------------------------------------------------
// fatr_cell
// one table slot: holds a range, compares it against the command and
// shifts with its neighbours when a range is inserted or removed
// ----------------------------------------------------------------------------
`default_nettype none

module fatr_cell
   import fatr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire ctl_type   ctl,
   input  wire nbr_type   left_in,
   input  wire nbr_type   right_in,
   input  wire chain_type chain_in,
   output nbr_type        self_out,
   output chain_type      chain_out
);

   logic        valid_ff, valid_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] high_ff, high_in;

   // compare results of the evaluate cycle
   logic hit_ff, ext_ff, ladj_ff, ins_ff, merge_ff;
   logic [31:0] up1, lm1;
   logic        merge_here;

   // compare stage
   always_comb begin
      up1 = seq_succ(high_ff);
      lm1 = seq_pred(low_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.eval_en) begin
         ext_ff   <= (up1 == ctl.seq);
         hit_ff   <= valid_ff && ((up1 == ctl.seq) || seq_before(ctl.seq, up1));
         ladj_ff  <= (lm1 == ctl.seq);
         ins_ff   <= seq_before(ctl.seq, lm1);
         merge_ff <= valid_ff && (low_ff == seq_succ(ctl.seq));
      end
   end

   // update stage
   always_comb begin
      valid_in   = valid_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      chain_out  = chain_in;
      merge_here = right_in.valid && right_in.merge;
      if (ctl.apply_en) begin
         case (ctl.func)
            FUNC_ACK: begin
               if (chain_in.found) begin
                  // a cell upstream handled it, follow its shift
                  if (chain_in.shift_r) begin
                     valid_in = left_in.valid;
                     low_in   = left_in.low;
                     high_in  = left_in.high;
                  end else if (chain_in.shift_l) begin
                     valid_in = right_in.valid;
                     low_in   = right_in.low;
                     high_in  = right_in.high;
                  end
               end else if (hit_ff) begin
                  chain_out.found = 1'b1;
                  if (ext_ff) begin
                     high_in           = merge_here ? right_in.high : ctl.seq;
                     chain_out.shift_l = merge_here;
                  end else if (ladj_ff) begin
                     low_in = ctl.seq;
                  end else if (ins_ff) begin
                     if (ctl.full) begin
                        chain_out.ovf = 1'b1;
                     end else begin
                        low_in            = ctl.seq;
                        high_in           = ctl.seq;
                        chain_out.shift_r = 1'b1;
                     end
                  end else begin
                     chain_out.dup = 1'b1;
                  end
               end else if (!valid_ff) begin
                  // first free slot: append
                  chain_out.found = 1'b1;
                  valid_in        = 1'b1;
                  low_in          = ctl.seq;
                  high_in         = ctl.seq;
               end
            end
            FUNC_POP: begin
               valid_in = right_in.valid;
               low_in   = right_in.low;
               high_in  = right_in.high;
            end
            FUNC_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
   end

   assign self_out = '{valid: valid_ff, merge: merge_ff, low: low_ff, high: high_ff};

endmodule

`default_nettype wire

// ===== rtl/fence_ack_range_tracker.sv =====
// ----------------------------------------------------------------------------
// fence_ack_range_tracker
// ordered table of acknowledged fence sequence ranges built as a cell chain
// ----------------------------------------------------------------------------
// Each transfer passes through an evaluate state and an update state. In
// the evaluate state every cell compares its range against the command and
// registers the outcome; in the update state a priority flag ripples down
// the row of cells and the table shifts, extends, merges or inserts in one
// step while the result is loaded into the output register. The next request
// is taken in the update state. A waiting result holds the update until taken.
// Table slots need no clearing pass after reset; only the per-cell valid
// flags are reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fence_ack_range_tracker_defines.svh"

module fence_ack_range_tracker
   import fatr_pkg::*;
#(
   parameter int MAX_RANGES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic [MAX_RANGES-1:0] VEC_ONE = MAX_RANGES'(1);

   state_type   state_ff, state_in;
   req_type     cmd_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [31:0] last_upper_ff, last_upper_in;

   logic            apply_fire;
   logic            req_xfer;
   ctl_type         ctl;
   nbr_type         nbr [MAX_RANGES];
   chain_type       chain [MAX_RANGES+1];
   logic [MAX_RANGES-1:0] valid_vec;
   logic            valid_gap;
   logic            pop_hit;
   chain_type       tail;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_xfer) state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_APPLY;
         ST_APPLY: begin
            if (apply_fire) begin
               state_in = req_xfer ? ST_EVAL : ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      apply_fire   = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
      req_ready    = (state_ff == ST_IDLE) || apply_fire;
      req_xfer     = req_valid && req_ready;
      ctl.eval_en  = (state_ff == ST_EVAL);
      ctl.apply_en = apply_fire;
      ctl.full     = valid_vec[MAX_RANGES-1];
      ctl.func     = cmd_ff.func;
      ctl.seq      = cmd_ff.ack_seq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_upper_ff <= 32'd0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_upper_ff <= last_upper_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // row of cells
   assign chain[0] = '0;

   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      nbr_type left_nbr, right_nbr;
      if (i == 0) begin : g_first
         assign left_nbr = '0;
      end else begin : g_mid_l
         assign left_nbr = nbr[i-1];
      end
      if (i == MAX_RANGES-1) begin : g_last
         assign right_nbr = '0;
      end else begin : g_mid_r
         assign right_nbr = nbr[i+1];
      end
      fatr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .left_in   (left_nbr),
         .right_in  (right_nbr),
         .chain_in  (chain[i]),
         .self_out  (nbr[i]),
         .chain_out (chain[i+1])
      );
      assign valid_vec[i] = nbr[i].valid;
   end

   // result of the update cycle
   always_comb begin
      tail          = chain[MAX_RANGES];
      pop_hit       = (cmd_ff.func == FUNC_POP) && nbr[0].valid;
      last_upper_in = last_upper_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      if (apply_fire) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.popped_lower   = pop_hit ? nbr[0].low : 32'd0;
         rsp_data_in.latched_upper  = pop_hit ? nbr[0].high : last_upper_ff;
         rsp_data_in.duplicate_ack  = 1'b0;
         rsp_data_in.table_overflow = 1'b0;
         if (pop_hit) begin
            last_upper_in = nbr[0].high;
         end
         case (cmd_ff.func)
            FUNC_ACK: begin
               rsp_data_in.ranges_pending = 1'b1;
               rsp_data_in.duplicate_ack  = tail.dup;
               rsp_data_in.table_overflow = tail.ovf || (!tail.found && ctl.full);
            end
            FUNC_POP:   rsp_data_in.ranges_pending = nbr[1].valid;
            FUNC_CLEAR: rsp_data_in.ranges_pending = 1'b0;
            default:    rsp_data_in.ranges_pending = nbr[0].valid;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // occupied slots must form one block from the head
   assign valid_gap = |((valid_vec + VEC_ONE) & valid_vec);

   `FATR_ASSERT(a_valid_packed, clock, reset, !valid_gap, "table slots not packed at head")
   `FATR_ASSERT(a_eval_then_apply, clock, reset, state_ff == ST_EVAL |=> state_ff == ST_APPLY,
                "evaluate cycle not followed by update")
   `FATR_ASSERT(a_req_to_eval, clock, reset, req_xfer |=> state_ff == ST_EVAL,
                "accepted request did not start evaluation")
   `FATR_ASSERT(a_rsp_from_apply, clock, reset, $rose(rsp_valid_ff) |-> $past(apply_fire),
                "result appeared outside an update cycle")
   `FATR_ASSERT(a_dup_ovf_excl, clock, reset,
                rsp_valid_ff |-> !(rsp_data_ff.duplicate_ack && rsp_data_ff.table_overflow),
                "duplicate and overflow flagged together")
   `FATR_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid_ff && state_ff == ST_IDLE,
                       "reset did not return to idle")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fence ack range tracker
// ----------------------------------------------------------------------------
// Requests come from a backlog that the stimulus block fills: first a
// directed run over wrap-around, extension at both ends, merging, duplicates,
// a full table, pops, clears and the unused code, then random windows of
// nearby sequence numbers mixed with pops, clears and noise. A local model of
// the range table predicts the status of every transfer, and the monitor
// compares each response field with the oldest prediction. Both channels
// idle at random, with calm stretches that have no idling at all.
// ----------------------------------------------------------------------------

module tb;
   import fatr_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   fence_ack_range_tracker #(
      .MAX_RANGES(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // requests waiting to be driven and responses still owed
   req_type req_backlog[$];
   rsp_type awaited_status[$];

   // local copy of the range table
   logic [31:0] tbl_lo[TABLE_DEPTH];
   logic [31:0] tbl_hi[TABLE_DEPTH];
   int          tbl_count = 0;
   logic [31:0] held_upper = '0;

   int mismatches = 0;
   int req_seen = 0;
   int rsp_seen = 0;
   int dup_seen = 0;
   int ovf_seen = 0;
   int pop_hits = 0;

   // idling control
   logic calm_on = 1'b0;
   int   calm_left = 0;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   quiet_cycles = 0;

   function automatic logic [31:0] next_seq(input logic [31:0] s);
      return (s == 32'hFFFF_FFFF) ? 32'd1 : s + 32'd1;
   endfunction

   function automatic logic [31:0] prev_seq(input logic [31:0] s);
      return (s == 32'd1) ? 32'hFFFF_FFFF : s - 32'd1;
   endfunction

   // serial order on the wrapped difference
   function automatic logic seq_earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic void remove_range(input int pos);
      for (int k = pos; k + 1 < tbl_count; k++) begin
         tbl_lo[k] = tbl_lo[k + 1];
         tbl_hi[k] = tbl_hi[k + 1];
      end
      tbl_count--;
   endfunction

   // update the table for one command and return the status it reports
   function automatic rsp_type advance_range_table(input req_type r);
      rsp_type     res;
      logic [31:0] up1;
      logic [31:0] lm1;
      bit          done;
      int          slot;
      res = '0;
      case (r.func)
         FUNC_ACK: begin
            done = 1'b0;
            slot = tbl_count;
            for (int i = 0; i < tbl_count && !done; i++) begin
               up1 = next_seq(tbl_hi[i]);
               if (up1 == r.ack_seq) begin
                  // extend upwards, then close the gap to the next range
                  tbl_hi[i] = r.ack_seq;
                  if (i + 1 < tbl_count && tbl_lo[i + 1] == next_seq(r.ack_seq)) begin
                     tbl_hi[i] = tbl_hi[i + 1];
                     remove_range(i + 1);
                  end
                  slot = -1;
                  done = 1'b1;
               end else if (seq_earlier(r.ack_seq, up1)) begin
                  lm1 = prev_seq(tbl_lo[i]);
                  if (lm1 == r.ack_seq) begin
                     tbl_lo[i] = r.ack_seq;
                     slot = -1;
                  end else if (seq_earlier(r.ack_seq, lm1)) begin
                     slot = i;
                  end else begin
                     res.duplicate_ack = 1'b1;
                     slot = -1;
                  end
                  done = 1'b1;
               end
            end
            // new single-point range, dropped when the table is full
            if (slot >= 0) begin
               if (tbl_count >= TABLE_DEPTH) begin
                  res.table_overflow = 1'b1;
               end else begin
                  for (int k = tbl_count; k > slot; k--) begin
                     tbl_lo[k] = tbl_lo[k - 1];
                     tbl_hi[k] = tbl_hi[k - 1];
                  end
                  tbl_lo[slot] = r.ack_seq;
                  tbl_hi[slot] = r.ack_seq;
                  tbl_count++;
               end
            end
         end
         FUNC_POP: begin
            if (tbl_count > 0) begin
               res.popped_lower = tbl_lo[0];
               held_upper = tbl_hi[0];
               remove_range(0);
            end
         end
         FUNC_CLEAR: begin
            tbl_count = 0;
         end
         default: begin
         end
      endcase
      res.latched_upper = held_upper;
      res.ranges_pending = (tbl_count > 0);
      return res;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", label, want, got);
         mismatches++;
      end
   endfunction

   // most gaps short, a few long, none in a calm stretch
   function automatic int pick_gap(input logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 45) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   function automatic void queue_cmd(input logic [1:0] func, input logic [31:0] seq);
      req_type r;
      r.func = func;
      r.ack_seq = seq;
      req_backlog.push_back(r);
   endfunction

   // calm stretches come and go
   always @(posedge clock) begin
      if (calm_left > 0) begin
         calm_left <= calm_left - 1;
      end else begin
         calm_left <= $urandom_range(50, 300);
         calm_on <= ($urandom_range(0, 2) == 0);
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_data <= req_backlog.pop_front();
            req_valid <= 1'b1;
            send_wait <= pick_gap(calm_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      int gap;
      gap = pick_gap(calm_on);
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
         rsp_ready <= (recv_wait == 1);
      end else if (rsp_valid && rsp_ready) begin
         recv_wait <= gap;
         rsp_ready <= (gap == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            awaited_status.push_back(advance_range_table(req_data));
            req_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (awaited_status.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatches++;
            end else begin
               want = awaited_status.pop_front();
               check_field("popped_lower", want.popped_lower, rsp_data.popped_lower);
               check_field("latched_upper", want.latched_upper, rsp_data.latched_upper);
               check_field("ranges_pending", 32'(want.ranges_pending),
                           32'(rsp_data.ranges_pending));
               check_field("duplicate_ack", 32'(want.duplicate_ack),
                           32'(rsp_data.duplicate_ack));
               check_field("table_overflow", 32'(want.table_overflow),
                           32'(rsp_data.table_overflow));
               dup_seen += int'(want.duplicate_ack);
               ovf_seen += int'(want.table_overflow);
               pop_hits += int'(want.popped_lower != '0);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      logic [31:0] base;
      int          span;
      int          run_len;
      int          r;
      int          made;

      // empty table, unused code, wrap-around through zero
      queue_cmd(FUNC_POP, 32'd0);
      queue_cmd(FUNC_UNUSED, 32'hFFFF_FFFF);
      queue_cmd(FUNC_ACK, 32'hFFFF_FFFF);
      queue_cmd(FUNC_ACK, 32'd1);
      queue_cmd(FUNC_ACK, 32'hFFFF_FFFE);
      queue_cmd(FUNC_ACK, 32'd0);
      queue_cmd(FUNC_ACK, 32'd3);
      queue_cmd(FUNC_ACK, 32'd2);
      queue_cmd(FUNC_POP, 32'hFFFF_FFFF);
      queue_cmd(FUNC_CLEAR, 32'hAAAA_5555);
      // fill the table back to front so every ack inserts in order
      for (int k = 15; k >= 0; k--) begin
         queue_cmd(FUNC_ACK, 32'd10 + 2 * k);
      end
      // full table: append and insert both overflow, merge and duplicate do not
      queue_cmd(FUNC_ACK, 32'd50);
      queue_cmd(FUNC_ACK, 32'd5);
      queue_cmd(FUNC_ACK, 32'd11);
      queue_cmd(FUNC_ACK, 32'd11);
      queue_cmd(FUNC_ACK, 32'd50);

      // random windows of nearby sequence numbers
      made = 0;
      while (made < 500) begin
         base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 30) : $urandom;
         span = ($urandom_range(0, 3) == 0) ? 80 : 30;
         run_len = $urandom_range(20, 60);
         for (int n = 0; n < run_len; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               queue_cmd(FUNC_ACK, base + $urandom_range(0, span));
            end else if (r < 82) begin
               queue_cmd(FUNC_POP, $urandom);
            end else if (r < 85) begin
               queue_cmd(FUNC_CLEAR, $urandom);
            end else if (r < 88) begin
               queue_cmd(FUNC_UNUSED, $urandom);
            end else if (r < 95) begin
               queue_cmd(FUNC_ACK, $urandom);
            end else begin
               queue_cmd(FUNC_ACK, base - $urandom_range(1, 20));
            end
         end
         made += run_len;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses to %0d commands", rsp_seen, req_seen);
      $display("seen: %0d duplicate acks, %0d overflows, %0d pops that returned a range",
               dup_seen, ovf_seen, pop_hits);
      if (mismatches == 0 && awaited_status.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
